[rtl/gtla_pkg.sv]
// Package for the greedy track label assignment block: types, sizes and states.
package gtla_pkg;

    localparam int MAX_DETS = 4;
    localparam int IDX_W    = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
    localparam int CNT_W    = $clog2(MAX_DETS + 1);
    localparam int DIST_W   = 33;
    localparam int SUM_W    = 16 + CNT_W;
    localparam int GATE_RESET = 480;

    localparam logic [2:0] LBL_TL = 3'd1;
    localparam logic [2:0] LBL_TR = 3'd2;
    localparam logic [2:0] LBL_BL = 3'd3;
    localparam logic [2:0] LBL_BR = 3'd4;

    typedef struct packed {
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic        last_det;
        logic        empty_frame;
    } req_t;

    typedef struct packed {
        logic [2:0] det_label;
        logic       inherited;
        logic       last_result;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAKE,
        ST_QUAD,
        ST_EMIT
    } state_t;

endpackage

[rtl/gtla_dist_unit.sv]
// Shared squared-distance unit: one axis difference squared per cycle, summed over both axes.
module gtla_dist_unit (
    input  logic                       clk,
    input  logic                       first,
    input  logic [15:0]                a,
    input  logic [15:0]                b,
    output logic [gtla_pkg::DIST_W-1:0] dist_sq
);
    import gtla_pkg::*;

    logic [15:0]       diff;
    logic [31:0]       sq_reg;
    logic [DIST_W-1:0] acc_reg;

    // Absolute difference feeds the squarer register.
    assign diff = (a >= b) ? (a - b) : (b - a);

    always_ff @(posedge clk)
    begin
        sq_reg  <= diff * diff;
        acc_reg <= first ? {1'b0, sq_reg} : (acc_reg + {1'b0, sq_reg});
    end

    assign dist_sq = acc_reg;
endmodule

[rtl/greedy_track_label_assign.sv]
// Top level of the greedy track label assignment block.
//
// A request loads one centroid; a non-final one leaves the block idle. The request
// with last_det set closes the frame: the block then scans every current and
// previous pair through one shared squarer, takes the best match, repeats the
// scan once per match taken, labels the unmatched ones by quadrant and then
// emits one result per cycle on the strobe. With n detections and m history
// entries at most min(n,m) matches are taken; with no history the scan is
// skipped. Results cannot be stalled by the receiver.
module greedy_track_label_assign (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  gtla_pkg::req_t      req,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    output logic                result_valid,
    output gtla_pkg::result_t   result
);
    import gtla_pkg::*;

    state_t state_reg, state_next;

    logic [15:0]      gate_reg;
    logic [15:0]      cur_x  [MAX_DETS];
    logic [15:0]      cur_y  [MAX_DETS];
    logic [15:0]      prev_x [MAX_DETS];
    logic [15:0]      prev_y [MAX_DETS];
    logic [2:0]       prev_label [MAX_DETS];
    logic [2:0]       label_reg  [MAX_DETS];
    logic [MAX_DETS-1:0] matched_reg, used_reg;
    logic [CNT_W-1:0] cur_cnt_reg, prev_cnt_reg;
    logic [SUM_W-1:0] sx_reg, sy_reg;

    // Scan position: current index, previous index, phase within a pair.
    logic [IDX_W-1:0] si_reg, sj_reg, bi_reg, bj_reg;
    logic [1:0]       ph_reg;
    logic             found_reg;
    logic [DIST_W-1:0] best_reg;
    logic [IDX_W-1:0] oi_reg;

    logic             accept;
    logic [DIST_W-1:0] pair_dist;
    logic [31:0]      gate_sq;
    logic [15:0]      ua, ub;
    logic             pair_ok, last_pair;
    logic [SUM_W+CNT_W-1:0] vx_n, vy_n;
    logic             top, left;

    assign accept  = start && !busy;
    assign gate_sq = gate_reg * gate_reg;

    // Feed the unit: x axis in phase 0, y axis in phase 1.
    assign ua = (ph_reg == 2'd0) ? cur_x[si_reg] : cur_y[si_reg];
    assign ub = (ph_reg == 2'd0) ? prev_x[sj_reg] : prev_y[sj_reg];

    gtla_dist_unit u_dist (
        .clk    (clk),
        .first  (ph_reg == 2'd1),
        .a      (ua),
        .b      (ub),
        .dist_sq(pair_dist)
    );

    // The pair counts when both sides are free; the distance is valid in phase 3.
    assign pair_ok   = !matched_reg[si_reg] && !used_reg[sj_reg];
    assign last_pair = ({1'b0, si_reg} == CNT_W'(cur_cnt_reg - 1'b1))
                    && ({1'b0, sj_reg} == CNT_W'(prev_cnt_reg - 1'b1));

    // Quadrant test for the entry at oi_reg: v * n < sum.
    assign vx_n = cur_x[oi_reg] * cur_cnt_reg;
    assign vy_n = cur_y[oi_reg] * cur_cnt_reg;
    assign left = vx_n < {{CNT_W{1'b0}}, sx_reg};
    assign top  = vy_n < {{CNT_W{1'b0}}, sy_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept && !req.empty_frame && req.last_det)
                    state_next = (prev_cnt_reg == '0) ? ST_QUAD : ST_SCAN;
            ST_SCAN:
                if (ph_reg == 2'd3 && last_pair)
                    state_next = ST_TAKE;
            ST_TAKE:
                state_next = found_reg ? ST_SCAN : ST_QUAD;
            ST_QUAD:
                if ({1'b0, oi_reg} == CNT_W'(cur_cnt_reg - 1'b1))
                    state_next = ST_EMIT;
            ST_EMIT:
                if ({1'b0, oi_reg} == CNT_W'(cur_cnt_reg - 1'b1))
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        busy         = (state_reg != ST_IDLE);
        result_valid = (state_reg == ST_EMIT);
        result.det_label   = label_reg[oi_reg];
        result.inherited   = matched_reg[oi_reg];
        result.last_result = ({1'b0, oi_reg} == CNT_W'(cur_cnt_reg - 1'b1));
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            gate_reg     <= 16'(GATE_RESET);
            cur_cnt_reg  <= '0;
            prev_cnt_reg <= '0;
            sx_reg       <= '0;
            sy_reg       <= '0;
            matched_reg  <= '0;
            used_reg     <= '0;
            si_reg       <= '0;
            sj_reg       <= '0;
            ph_reg       <= '0;
            found_reg    <= 1'b0;
            oi_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                gate_reg <= cfg_wdata;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (req.empty_frame)
                        begin
                            prev_cnt_reg <= '0;
                            cur_cnt_reg  <= '0;
                            sx_reg       <= '0;
                            sy_reg       <= '0;
                        end
                        else
                        begin
                            if (cur_cnt_reg < CNT_W'(MAX_DETS))
                            begin
                                cur_cnt_reg <= cur_cnt_reg + 1'b1;
                                sx_reg <= sx_reg + SUM_W'(req.x_pos);
                                sy_reg <= sy_reg + SUM_W'(req.y_pos);
                            end
                            matched_reg <= '0;
                            used_reg    <= '0;
                            si_reg      <= '0;
                            sj_reg      <= '0;
                            ph_reg      <= '0;
                            found_reg   <= 1'b0;
                            oi_reg      <= '0;
                        end
                    end
                end
                ST_SCAN:
                begin
                    ph_reg <= ph_reg + 2'd1;
                    if (ph_reg == 2'd3)
                    begin
                        if (pair_ok && pair_dist <= {1'b0, gate_sq}
                            && (!found_reg || pair_dist < best_reg))
                            found_reg <= 1'b1;
                        if ({1'b0, sj_reg} == CNT_W'(prev_cnt_reg - 1'b1))
                        begin
                            sj_reg <= '0;
                            si_reg <= si_reg + 1'b1;
                        end
                        else
                            sj_reg <= sj_reg + 1'b1;
                    end
                end
                ST_TAKE:
                begin
                    if (found_reg)
                    begin
                        matched_reg[bi_reg] <= 1'b1;
                        used_reg[bj_reg]    <= 1'b1;
                    end
                    found_reg <= 1'b0;
                    si_reg    <= '0;
                    sj_reg    <= '0;
                    ph_reg    <= '0;
                end
                ST_QUAD:
                begin
                    if ({1'b0, oi_reg} == CNT_W'(cur_cnt_reg - 1'b1))
                        oi_reg <= '0;
                    else
                        oi_reg <= oi_reg + 1'b1;
                end
                ST_EMIT:
                begin
                    if ({1'b0, oi_reg} == CNT_W'(cur_cnt_reg - 1'b1))
                    begin
                        oi_reg       <= '0;
                        prev_cnt_reg <= cur_cnt_reg;
                        cur_cnt_reg  <= '0;
                        sx_reg       <= '0;
                        sy_reg       <= '0;
                    end
                    else
                        oi_reg <= oi_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload storage: centroids, best candidate, labels and history.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept && !req.empty_frame
            && cur_cnt_reg < CNT_W'(MAX_DETS))
        begin
            cur_x[cur_cnt_reg[IDX_W-1:0]] <= req.x_pos;
            cur_y[cur_cnt_reg[IDX_W-1:0]] <= req.y_pos;
        end
        if (state_reg == ST_SCAN && ph_reg == 2'd3 && pair_ok
            && pair_dist <= {1'b0, gate_sq} && (!found_reg || pair_dist < best_reg))
        begin
            best_reg <= pair_dist;
            bi_reg   <= si_reg;
            bj_reg   <= sj_reg;
        end
        if (state_reg == ST_TAKE && found_reg)
            label_reg[bi_reg] <= prev_label[bj_reg];
        if (state_reg == ST_QUAD && !matched_reg[oi_reg])
        begin
            if (top && left)
                label_reg[oi_reg] <= LBL_TL;
            else if (top)
                label_reg[oi_reg] <= LBL_TR;
            else if (left)
                label_reg[oi_reg] <= LBL_BL;
            else
                label_reg[oi_reg] <= LBL_BR;
        end
        if (state_reg == ST_EMIT)
        begin
            prev_x[oi_reg]     <= cur_x[oi_reg];
            prev_y[oi_reg]     <= cur_y[oi_reg];
            prev_label[oi_reg] <= label_reg[oi_reg];
        end
    end
endmodule
